>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk, switched off while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, also during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/wfmw_pkg.sv
// ----------------------------------------------------------------------------
// Maze walker package
// Request codes, heading codes, probe order and neighbor arithmetic.
// ----------------------------------------------------------------------------
package wfmw_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Headings.
  localparam logic [1:0] HEAD_RIGHT = 2'd0;
  localparam logic [1:0] HEAD_LEFT  = 2'd1;
  localparam logic [1:0] HEAD_UP    = 2'd2;
  localparam logic [1:0] HEAD_DOWN  = 2'd3;

  // Smallest side length the walker honors.
  localparam logic [6:0] SIZE_MIN = 7'd3;

  // Slot of the last neighbor probe; the slot after it holds the reverse heading.
  localparam logic [1:0] PROBE_LAST    = 2'd2;
  localparam logic [1:0] PROBE_REVERSE = 2'd3;

  // For each heading: three probe directions in priority order, then the reverse.
  localparam logic [1:0] PROBE_ORDER [4][4] = '{
    '{HEAD_DOWN,  HEAD_RIGHT, HEAD_UP,    HEAD_LEFT },
    '{HEAD_UP,    HEAD_LEFT,  HEAD_DOWN,  HEAD_RIGHT},
    '{HEAD_RIGHT, HEAD_UP,    HEAD_LEFT,  HEAD_DOWN },
    '{HEAD_LEFT,  HEAD_DOWN,  HEAD_RIGHT, HEAD_UP   }
  };

  // Neighbor position; bit 7 set means the coordinate went below zero.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } pos_t;

  // Memory cell: bit 0 open, bit 1 marked.
  typedef struct packed {
    logic marked;
    logic open;
  } cell_t;

  function automatic pos_t step_pos(input logic [6:0] x, input logic [6:0] y,
                                    input logic [1:0] dir);
    pos_t p;
    p.x = {1'b0, x};
    p.y = {1'b0, y};
    case (dir)
      HEAD_RIGHT: p.x = {1'b0, x} + 8'd1;
      HEAD_LEFT:  p.x = {1'b0, x} - 8'd1;
      HEAD_UP:    p.y = {1'b0, y} - 8'd1;
      HEAD_DOWN:  p.y = {1'b0, y} + 8'd1;
      default:    p.x = {1'b0, x};
    endcase
    return p;
  endfunction

endpackage

>>> rtl/wall_follower_maze_walker_core.sv
// ----------------------------------------------------------------------------
// Wall-follower maze walker core
// Square maze bitmap in one memory, walked one cell per step request.
// ----------------------------------------------------------------------------
// Usage: every word on the slave stream is one request, selected by s_tuser:
// load a pixel (writes its open bit and clears its mark), step the walker, or
// read a pixel. Every request gives exactly one word on the master stream with
// the walker position, heading and done flag, plus the pixel bits for a read.
// The maze side length is written through cfg_we/cfg_wdata while idle.
//
// Sequencing: a load, a read or a step after the walk has ended goes through
// the result state to the result register; a step that ends on the goal or
// outside the maze passes the check state first. A moving step runs a check,
// up to three neighbor probes (read and check, or the bounds test alone outside
// the maze), a move and the result state; the first step first marks the start
// pixel. The bitmap memory has a single read port, so neighbors are probed one
// at a time. A new word is taken only once the result is registered.
//
// Reset clears the walker to (0,1) heading right and the size to 64 or to a
// smaller MAX_SIZE; the bitmap is not cleared and must be loaded before it is
// read or walked. On a receiver stall the result stays in the output register
// and one more request may be accepted, worked on and held until it frees.
module wall_follower_maze_walker_core #(
  parameter int MAX_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: maze side length in pixels.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pixel_x[5:0], pixel_y[11:6], open_in[12], zero fill
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // walker_x[5:0], walker_y[11:6], walker_heading[13:12],
                                 // walk_done[14], read_open[15], read_marked[16], zero fill
);

  // Storage geometry: rows and columns of the bitmap take CW address bits each.
  localparam int CW    = $clog2(MAX_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = (CW > 7) ? CW : 7;
  // Largest side length the 7-bit register and the storage allow together.
  localparam int          SMAX       = (MAX_SIZE < 127) ? MAX_SIZE : 127;
  localparam logic [6:0]  SIZE_MAX   = 7'(SMAX);
  localparam logic [6:0]  SIZE_RESET = (SMAX < 64) ? SIZE_MAX : 7'd64;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_START     = 8'b0000_0010,
    S_START_CHK = 8'b0000_0100,
    S_CHECK     = 8'b0000_1000,
    S_PROBE     = 8'b0001_0000,
    S_PROBE_CHK = 8'b0010_0000,
    S_MOVE      = 8'b0100_0000,
    S_RESULT    = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] x, input logic [6:0] y);
    logic [EW-1:0] xe;
    logic [EW-1:0] ye;
    xe = EW'(x);
    ye = EW'(y);
    return {ye[CW-1:0], xe[CW-1:0]};
  endfunction

  function automatic logic [6:0] clamp_size(input logic [6:0] v);
    logic [6:0] s;
    s = v;
    if (v < wfmw_pkg::SIZE_MIN) begin
      s = wfmw_pkg::SIZE_MIN;
    end else if (v > SIZE_MAX) begin
      s = SIZE_MAX;
    end
    return s;
  endfunction

  // Walker and control registers.
  state_t     state;
  logic [6:0] size_eff;
  logic [6:0] cur_x;
  logic [6:0] cur_y;
  logic [1:0] heading;
  logic       started;
  logic       finished;
  logic [1:0] probe_k;
  logic [1:0] move_d;
  logic       rd_flag;

  // Bitmap memory.
  wfmw_pkg::cell_t mem [DEPTH];
  wfmw_pkg::cell_t rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  wfmw_pkg::cell_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  // Request fields.
  logic [1:0] req_type;
  logic [5:0] pixel_x;
  logic [5:0] pixel_y;
  logic       open_in;
  logic       accept;
  logic       store_ok;

  assign req_type = s_tuser;
  assign pixel_x  = s_tdata[5:0];
  assign pixel_y  = s_tdata[11:6];
  assign open_in  = s_tdata[12];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign store_ok = (int'(pixel_x) < MAX_SIZE) && (int'(pixel_y) < MAX_SIZE);

  // Neighbor under test: the probe slot while probing, the chosen heading when moving.
  logic [1:0]     probe_d;
  logic [1:0]     dir_sel;
  wfmw_pkg::pos_t nb;
  logic           nb_in;
  logic           nb_goal;
  logic           cur_in;
  logic           cur_goal;

  assign probe_d  = wfmw_pkg::PROBE_ORDER[heading][probe_k];
  assign dir_sel  = (state == S_MOVE) ? move_d : probe_d;
  assign nb       = wfmw_pkg::step_pos(cur_x, cur_y, dir_sel);
  assign nb_in    = !nb.x[7] && !nb.y[7] && (nb.x[6:0] < size_eff) && (nb.y[6:0] < size_eff);
  assign nb_goal  = (nb.x[6:0] == size_eff - 7'd1) && (nb.y[6:0] == size_eff - 7'd2);
  assign cur_in   = (cur_x < size_eff) && (cur_y < size_eff);
  assign cur_goal = (cur_x == size_eff - 7'd1) && (cur_y == size_eff - 7'd2);

  // Memory port control. Writes and reads of one cell never fall in the same
  // cycle: each write is followed by a state that issues no read of that cell.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(cur_x, cur_y);
    mem_wdata = '{marked: 1'b1, open: 1'b1};
    mem_re    = 1'b0;
    mem_raddr = cell_addr(cur_x, cur_y);
    case (state)
      S_IDLE: begin
        if (accept && store_ok && req_type == wfmw_pkg::REQ_LOAD) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr({1'b0, pixel_x}, {1'b0, pixel_y});
          mem_wdata = '{marked: 1'b0, open: open_in};
        end
        if (accept && store_ok && req_type == wfmw_pkg::REQ_READ) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr({1'b0, pixel_x}, {1'b0, pixel_y});
        end
      end
      S_START: begin
        mem_re = cur_in;
      end
      S_START_CHK: begin
        mem_we = cur_in && rdata.open;
      end
      S_PROBE: begin
        mem_re    = nb_in;
        mem_raddr = cell_addr(nb.x[6:0], nb.y[6:0]);
      end
      S_PROBE_CHK: begin
        mem_we    = rdata.open;
        mem_waddr = cell_addr(nb.x[6:0], nb.y[6:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      size_eff <= SIZE_RESET;
      cur_x    <= 7'd0;
      cur_y    <= 7'd1;
      heading  <= wfmw_pkg::HEAD_RIGHT;
      started  <= 1'b0;
      finished <= 1'b0;
      probe_k  <= 2'd0;
      m_tvalid <= 1'b0;
      rd_flag  <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_eff <= clamp_size(cfg_wdata);
      end
      // The result state loads the next word itself when the register frees.
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_flag <= store_ok && (req_type == wfmw_pkg::REQ_READ);
            if (req_type == wfmw_pkg::REQ_STEP && !finished) begin
              state <= started ? S_CHECK : S_START;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_START: begin
          started <= 1'b1;
          state   <= S_START_CHK;
        end
        S_START_CHK: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!cur_in || cur_goal) begin
            finished <= 1'b1;
            state    <= S_RESULT;
          end else begin
            probe_k <= 2'd0;
            state   <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (nb_in) begin
            state <= S_PROBE_CHK;
          end else if (probe_k == wfmw_pkg::PROBE_LAST) begin
            move_d <= wfmw_pkg::PROBE_ORDER[heading][wfmw_pkg::PROBE_REVERSE];
            state  <= S_MOVE;
          end else begin
            probe_k <= probe_k + 2'd1;
          end
        end
        S_PROBE_CHK: begin
          if (rdata.open) begin
            move_d <= probe_d;
            state  <= S_MOVE;
          end else if (probe_k == wfmw_pkg::PROBE_LAST) begin
            move_d <= wfmw_pkg::PROBE_ORDER[heading][wfmw_pkg::PROBE_REVERSE];
            state  <= S_MOVE;
          end else begin
            probe_k <= probe_k + 2'd1;
            state   <= S_PROBE;
          end
        end
        S_MOVE: begin
          heading <= move_d;
          if (nb_in) begin
            cur_x <= nb.x[6:0];
            cur_y <= nb.y[6:0];
            if (nb_goal) begin
              finished <= 1'b1;
            end
          end else begin
            // A turn-around off the edge leaves the walker in place and ends the walk.
            finished <= 1'b1;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, rd_flag && rdata.marked, rd_flag && rdata.open, finished,
                         heading, cur_y[5:0], cur_x[5:0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  // Once the walk has ended it stays ended until reset.
  `ASSERT_CLK(a_finished_holds, clk, rst, !$past(rst) |-> !$fell(finished), "walk_done dropped without reset")

  // The walker only moves in the move state.
  `ASSERT_CLK(a_move_only, clk, rst, (!$past(rst) && (!$stable(cur_x) || !$stable(cur_y))) |-> ($past(state) == S_MOVE), "walker moved outside the move state")

  // Bitmap writes come only from a load, from marking the start pixel or from marking a probed pixel.
  `ASSERT_CLK(a_write_src, clk, rst, mem_we |-> (state == S_IDLE || state == S_START_CHK || state == S_PROBE_CHK), "bitmap written from an unexpected state")

  // A probe check always uses the data read in the cycle before.
  `ASSERT_CLK(a_probe_read, clk, rst, (state == S_PROBE_CHK) |-> ($past(state) == S_PROBE && $past(mem_re)), "probe check without a preceding read")

endmodule
